/* rtl/btda_pkg.sv */
// Shared types and constants for the binary to decimal ASCII converter.
package btda_pkg;

   localparam int VALUE_W      = 32;
   localparam int MIN_DIGITS_W = 4;
   localparam int CHAR_W       = 6;
   localparam int BCD_DIGITS   = 10;
   localparam int BIT_CNT_W    = 5;

   localparam logic [CHAR_W-1:0]    ASCII_ZERO = CHAR_W'(48);
   localparam logic [BIT_CNT_W-1:0] LAST_BIT   = BIT_CNT_W'(VALUE_W - 1);

   typedef struct packed {
      logic [VALUE_W-1:0]      value;
      logic [MIN_DIGITS_W-1:0] min_digits;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

endpackage

/* rtl/binary_to_decimal_ascii_core.sv */
// Top level of the binary to zero-padded decimal ASCII converter.
//
// A transaction enters on req_data when start is high and busy is low. It carries
// a 32-bit unsigned value and a minimum character count. The block answers with
// one rsp transaction per decimal character, most significant first, each shown
// on rsp_data for exactly one cycle while rsp_strobe is high. The last character
// of a value has rsp_data.last set. The value is padded on the left with '0'
// characters up to the minimum count, which saturates at MAX_DIGITS; at least
// one digit is always produced, and no significant digit is ever dropped.
//
// Timing: the shift-add-3 converter takes one input bit per cycle, through a
// single shared adjust-and-shift unit. The emit sequencer then walks the
// max(10, MAX_DIGITS) digit positions from the top, one per cycle, whether a
// position is emitted or skipped as a leading zero. Busy is high while an item
// is converted and emitted. The final character leaves the output register in
// the cycle busy drops, so a new transaction can be accepted in that same cycle.
// The receiver cannot stall: every strobed character counts as taken.
// A synchronous reset returns the block to idle with no strobe pending.
module binary_to_decimal_ascii_core #(
   parameter int MAX_DIGITS = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  btda_pkg::req_type req_data,
   output logic              rsp_strobe,
   output btda_pkg::rsp_type rsp_data
);

   // Number of digit positions the emit sequencer scans.
   localparam int SCAN   = (MAX_DIGITS > btda_pkg::BCD_DIGITS) ? MAX_DIGITS
                                                               : btda_pkg::BCD_DIGITS;
   localparam int IDXW   = $clog2(SCAN);
   // Wide enough for a position index, the minimum count and MAX_DIGITS itself.
   localparam int CW     = ($clog2(SCAN + 1) > btda_pkg::MIN_DIGITS_W) ? $clog2(SCAN + 1)
                                                                       : btda_pkg::MIN_DIGITS_W;
   localparam logic [CW-1:0]   MAX_W     = CW'(MAX_DIGITS);
   localparam logic [IDXW-1:0] TOP_IDX   = IDXW'(SCAN - 1);
   localparam logic [CW-1:0]   NUM_BCD   = CW'(btda_pkg::BCD_DIGITS);

   btda_pkg::state_type state_ff, state_in;

   logic [btda_pkg::VALUE_W-1:0]   value_ff, value_in;
   logic [3:0]                     bcd_ff [btda_pkg::BCD_DIGITS];
   logic [3:0]                     bcd_in [btda_pkg::BCD_DIGITS];
   logic [btda_pkg::BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [IDXW-1:0]                idx_ff, idx_in;
   logic [CW-1:0]                  width_ff, width_in;
   logic                           started_ff, started_in;
   logic                           rsp_strobe_ff, rsp_strobe_in;
   btda_pkg::rsp_type              rsp_ff, rsp_in;

   logic [3:0]    bcd_adj [btda_pkg::BCD_DIGITS];
   logic [3:0]    cur_digit;
   logic [CW-1:0] idx_ext;
   logic [CW-1:0] min_ext;
   logic          accept;
   logic          skip;

   assign accept  = start && (state_ff == btda_pkg::ST_IDLE);
   assign idx_ext = CW'(idx_ff);
   assign min_ext = CW'(req_data.min_digits);

   // The shared unit: add three to every BCD digit of five or more before the shift.
   always_comb begin
      for (int d = 0; d < btda_pkg::BCD_DIGITS; d++) begin
         bcd_adj[d] = (bcd_ff[d] >= 4'd5) ? (bcd_ff[d] + 4'd3) : bcd_ff[d];
      end
   end

   // Positions above the BCD register read as zero; they only ever pad.
   always_comb begin
      cur_digit = 4'd0;
      if (idx_ext < NUM_BCD) begin
         cur_digit = bcd_ff[idx_ext[$clog2(btda_pkg::BCD_DIGITS)-1:0]];
      end
   end

   // A leading zero above the minimum width is skipped, but never the units digit.
   assign skip = !started_ff && (cur_digit == 4'd0) && (idx_ext >= width_ff)
                 && (idx_ff != '0);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         btda_pkg::ST_IDLE: begin
            if (start) state_in = btda_pkg::ST_CONVERT;
         end
         btda_pkg::ST_CONVERT: begin
            if (bit_cnt_ff == btda_pkg::LAST_BIT) state_in = btda_pkg::ST_EMIT;
         end
         btda_pkg::ST_EMIT: begin
            if (idx_ff == '0) state_in = btda_pkg::ST_IDLE;
         end
         default: state_in = btda_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      value_in      = value_ff;
      bcd_in        = bcd_ff;
      bit_cnt_in    = bit_cnt_ff;
      idx_in        = idx_ff;
      width_in      = width_ff;
      started_in    = started_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      unique case (state_ff)
         btda_pkg::ST_IDLE: begin
            if (accept) begin
               value_in   = req_data.value;
               width_in   = (min_ext > MAX_W) ? MAX_W : min_ext;
               bit_cnt_in = '0;
               started_in = 1'b0;
               for (int d = 0; d < btda_pkg::BCD_DIGITS; d++) begin
                  bcd_in[d] = 4'd0;
               end
            end
         end
         btda_pkg::ST_CONVERT: begin
            // Shift the adjusted digits left by one, feeding in the next value bit.
            bcd_in[0] = {bcd_adj[0][2:0], value_ff[btda_pkg::VALUE_W-1]};
            for (int d = 1; d < btda_pkg::BCD_DIGITS; d++) begin
               bcd_in[d] = {bcd_adj[d][2:0], bcd_adj[d-1][3]};
            end
            value_in   = {value_ff[btda_pkg::VALUE_W-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + 1'b1;
            idx_in     = TOP_IDX;
         end
         btda_pkg::ST_EMIT: begin
            if (!skip) begin
               rsp_strobe_in     = 1'b1;
               rsp_in.digit_char = btda_pkg::ASCII_ZERO + {2'b00, cur_digit};
               rsp_in.last       = (idx_ff == '0);
               started_in        = 1'b1;
            end
            idx_in = idx_ff - 1'b1;
         end
         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= btda_pkg::ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      value_ff   <= value_in;
      bcd_ff     <= bcd_in;
      bit_cnt_ff <= bit_cnt_in;
      idx_ff     <= idx_in;
      width_ff   <= width_in;
      started_ff <= started_in;
      rsp_ff     <= rsp_in;
   end

   assign busy       = (state_ff != btda_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

/* rtl/btda_checker.sv */
// Port-level checker for the converter and the bind that attaches it.
module btda_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input btda_pkg::rsp_type rsp_data
);

   // After reset the block is idle and quiet.
   a_reset_idle: assert property (@(posedge clock) reset |=> (!busy && !rsp_strobe))
      else $error("block not idle after reset");

   // An accepted transaction makes the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after a transaction was accepted");

   // Conversion runs first, so no character follows an accept directly.
   a_no_early_char: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_strobe)
      else $error("character strobed right after accept");

   // Every character is a decimal digit.
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_data.digit_char >= 6'd48) && (rsp_data.digit_char <= 6'd57)))
      else $error("character outside 0 to 9");

   // The final character ends the value; with no new transaction offered in
   // that cycle, the block stays idle and quiet afterward.
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.last && !start) |=> (!rsp_strobe && !busy))
      else $error("activity after the final character");

endmodule

bind binary_to_decimal_ascii_core btda_checker u_btda_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
